// File: design/json_string_unescaper_top_macros.svh
// ---------------------------------------------------------------------------
// json string unescaper assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg
// types and constants shared by the json string unescaper modules
// ---------------------------------------------------------------------------
package jsu_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	// result status codes
	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_DONE    = 3'd1;
	localparam logic [2:0] ST_NOQUOTE = 3'd2;
	localparam logic [2:0] ST_TOOLONG = 3'd3;
	localparam logic [2:0] ST_BADHEX  = 3'd4;
	localparam logic [2:0] ST_BADESC  = 3'd5;
	localparam logic [2:0] ST_CTRL    = 3'd6;
	localparam logic [2:0] ST_UNTERM  = 3'd7;

	localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
	localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CTRL_LIM  = 8'h20;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  hex_count;
		logic [15:0] code_point;
		logic [16:0] decoded_count;
	} jsu_state_t;

	// up to four results caused by one source word
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [3:0][2:0] stat;
		logic [2:0]      count;
	} jsu_bundle_t;

endpackage

// File: design/jsu_decode.sv
// ---------------------------------------------------------------------------
// jsu_decode
// combinational step: current state and one source word in, next state and
// the bundle of results out
// ---------------------------------------------------------------------------
module jsu_decode (
	input  jsu_pkg::jsu_state_t  st,
	input  logic [15:0]          max_length,
	input  logic [7:0]           in_byte,
	input  logic                 begin_req,
	input  logic                 final_req,
	output jsu_pkg::jsu_state_t  st_next,
	output jsu_pkg::jsu_bundle_t bundle
);

	logic        too_long;
	logic        is_digit;
	logic        is_lower;
	logic        is_upper;
	logic        hex_ok;
	logic [3:0]  hex_d;
	logic [15:0] cp_new;
	logic [1:0]  utf_n;
	logic [7:0]  utf_b0;
	logic [7:0]  utf_b1;
	logic [7:0]  utf_b2;
	logic        esc_simple;
	logic [7:0]  esc_byte;
	logic [1:0]  add_n;
	logic [17:0] count_sum;
	logic [16:0] count_sat;
	jsu_pkg::jsu_state_t st_pre;

	assign too_long = st.decoded_count >= {1'b0, max_length};

	assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h66);
	assign is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h46);
	assign hex_ok   = is_digit || is_lower || is_upper;
	// letters have low nibble 1..6 for a..f
	assign hex_d    = is_digit ? in_byte[3:0] : in_byte[3:0] + 4'd9;
	assign cp_new   = {st.code_point[11:0], hex_d};

	always_comb begin
		if (cp_new < 16'h0080) begin
			utf_n  = 2'd1;
			utf_b0 = cp_new[7:0];
			utf_b1 = 8'h00;
			utf_b2 = 8'h00;
		end else if (cp_new < 16'h0800) begin
			utf_n  = 2'd2;
			utf_b0 = 8'hC0 | {3'b000, cp_new[10:6]};
			utf_b1 = 8'h80 | {2'b00, cp_new[5:0]};
			utf_b2 = 8'h00;
		end else begin
			utf_n  = 2'd3;
			utf_b0 = 8'hE0 | {4'h0, cp_new[15:12]};
			utf_b1 = 8'h80 | {2'b00, cp_new[11:6]};
			utf_b2 = 8'h80 | {2'b00, cp_new[5:0]};
		end
	end

	always_comb begin
		esc_simple = 1'b1;
		case (in_byte)
			jsu_pkg::CH_QUOTE:  esc_byte = jsu_pkg::CH_QUOTE;
			jsu_pkg::CH_BSLASH: esc_byte = jsu_pkg::CH_BSLASH;
			jsu_pkg::CH_SLASH:  esc_byte = jsu_pkg::CH_SLASH;
			8'h62:              esc_byte = 8'h08;
			8'h66:              esc_byte = 8'h0C;
			8'h6E:              esc_byte = 8'h0A;
			8'h72:              esc_byte = 8'h0D;
			8'h74:              esc_byte = 8'h09;
			default: begin
				esc_byte   = 8'h00;
				esc_simple = 1'b0;
			end
		endcase
	end

	// data bytes this word adds to the decoded count
	always_comb begin
		add_n = 2'd0;
		if (!begin_req) begin
			case (st.phase)
				jsu_pkg::PH_BODY: begin
					if (in_byte != jsu_pkg::CH_QUOTE && !too_long &&
					    in_byte != jsu_pkg::CH_BSLASH && in_byte >= jsu_pkg::CTRL_LIM)
						add_n = 2'd1;
				end
				jsu_pkg::PH_ESC: begin
					if (esc_simple)
						add_n = 2'd1;
				end
				jsu_pkg::PH_HEX: begin
					if (hex_ok && st.hex_count == 2'd3)
						add_n = utf_n;
				end
				default: add_n = 2'd0;
			endcase
		end
	end

	assign count_sum = {1'b0, st.decoded_count} + {16'b0, add_n};
	assign count_sat = count_sum[17] ? jsu_pkg::COUNT_MAX : count_sum[16:0];

	// next state
	always_comb begin
		st_pre = st;
		if (begin_req) begin
			st_pre.hex_count     = 2'd0;
			st_pre.code_point    = 16'h0000;
			st_pre.decoded_count = 17'd0;
			st_pre.phase = (in_byte == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_BODY : jsu_pkg::PH_IDLE;
		end else begin
			st_pre.decoded_count = count_sat;
			case (st.phase)
				jsu_pkg::PH_BODY: begin
					if (in_byte == jsu_pkg::CH_QUOTE || too_long)
						st_pre.phase = jsu_pkg::PH_IDLE;
					else if (in_byte == jsu_pkg::CH_BSLASH)
						st_pre.phase = jsu_pkg::PH_ESC;
					else if (in_byte < jsu_pkg::CTRL_LIM)
						st_pre.phase = jsu_pkg::PH_IDLE;
				end
				jsu_pkg::PH_ESC: begin
					if (esc_simple) begin
						st_pre.phase = jsu_pkg::PH_BODY;
					end else if (in_byte == jsu_pkg::CH_U) begin
						st_pre.phase      = jsu_pkg::PH_HEX;
						st_pre.hex_count  = 2'd0;
						st_pre.code_point = 16'h0000;
					end else begin
						st_pre.phase = jsu_pkg::PH_IDLE;
					end
				end
				jsu_pkg::PH_HEX: begin
					if (!hex_ok) begin
						st_pre.phase = jsu_pkg::PH_IDLE;
					end else begin
						st_pre.code_point = cp_new;
						if (st.hex_count == 2'd3) begin
							st_pre.hex_count = 2'd0;
							st_pre.phase     = jsu_pkg::PH_BODY;
						end else begin
							st_pre.hex_count = st.hex_count + 2'd1;
						end
					end
				end
				default: st_pre = st;
			endcase
		end
	end

	always_comb begin
		st_next = st_pre;
		if (final_req && st_pre.phase != jsu_pkg::PH_IDLE)
			st_next.phase = jsu_pkg::PH_IDLE;
	end

	// results
	always_comb begin
		bundle = '0;
		if (begin_req) begin
			if (in_byte != jsu_pkg::CH_QUOTE) begin
				bundle.stat[0] = jsu_pkg::ST_NOQUOTE;
				bundle.count   = 3'd1;
			end
		end else begin
			case (st.phase)
				jsu_pkg::PH_BODY: begin
					if (in_byte == jsu_pkg::CH_QUOTE) begin
						bundle.stat[0] = jsu_pkg::ST_DONE;
						bundle.count   = 3'd1;
					end else if (too_long) begin
						bundle.stat[0] = jsu_pkg::ST_TOOLONG;
						bundle.count   = 3'd1;
					end else if (in_byte == jsu_pkg::CH_BSLASH) begin
						bundle.count = 3'd0;
					end else if (in_byte < jsu_pkg::CTRL_LIM) begin
						bundle.stat[0] = jsu_pkg::ST_CTRL;
						bundle.count   = 3'd1;
					end else begin
						bundle.bytes[0] = in_byte;
						bundle.count    = 3'd1;
					end
				end
				jsu_pkg::PH_ESC: begin
					if (esc_simple) begin
						bundle.bytes[0] = esc_byte;
						bundle.count    = 3'd1;
					end else if (in_byte != jsu_pkg::CH_U) begin
						bundle.stat[0] = jsu_pkg::ST_BADESC;
						bundle.count   = 3'd1;
					end
				end
				jsu_pkg::PH_HEX: begin
					if (!hex_ok) begin
						bundle.stat[0] = jsu_pkg::ST_BADHEX;
						bundle.count   = 3'd1;
					end else if (st.hex_count == 2'd3) begin
						bundle.bytes[0] = utf_b0;
						bundle.bytes[1] = utf_b1;
						bundle.bytes[2] = utf_b2;
						bundle.count    = {1'b0, utf_n};
					end
				end
				default: bundle.count = 3'd0;
			endcase
		end
		// source ended with the string still open
		if (final_req && st_pre.phase != jsu_pkg::PH_IDLE) begin
			bundle.stat[bundle.count[1:0]] = jsu_pkg::ST_UNTERM;
			bundle.count = bundle.count + 3'd1;
		end
	end

endmodule

// File: design/jsu_out_buf.sv
// ---------------------------------------------------------------------------
// jsu_out_buf
// result register: holds the results of one word and, while out_ready is
// high, hands them out one per cycle
// ---------------------------------------------------------------------------
module jsu_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  jsu_pkg::jsu_bundle_t bundle,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic [2:0]           status,
	output logic                 run_end
);

	jsu_pkg::jsu_bundle_t bund_q;
	logic [1:0]           idx_q;
	logic                 vld_q;
	logic                 last;

	assign last      = ({1'b0, idx_q} + 3'd1) == bund_q.count;
	assign free      = !vld_q || (out_ready && last);
	assign out_valid = vld_q;
	assign out_byte  = bund_q.bytes[idx_q];
	assign status    = bund_q.stat[idx_q];
	assign run_end   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			vld_q <= bundle.count != 3'd0;
			idx_q <= 2'd0;
		end else if (vld_q && out_ready) begin
			if (last)
				vld_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			bund_q <= bundle;
	end

endmodule

// File: design/json_string_unescaper_top.sv
// path: a taken word waits in the input stage until the result register is free, then loads it
// throughput: one word per cycle while each word gives at most one result and out_ready
// is high; a word with more results (up to 4) holds the result register until all are taken
// reset: arst_n clears the pipeline, the string state and sets max_length to 4096
// ---------------------------------------------------------------------------
// json_string_unescaper_top
// decodes a quoted json string body, escapes and \u sequences to utf-8
// ---------------------------------------------------------------------------
module json_string_unescaper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        begin_req,
	input  logic        final_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [2:0]  status,
	output logic        run_end,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 begin_s1;
	logic                 final_s1;
	logic [15:0]          max_len_q;
	jsu_pkg::jsu_state_t  st_q;
	jsu_pkg::jsu_state_t  st_next;
	jsu_pkg::jsu_bundle_t bundle;
	logic                 buf_free;
	logic                 advance;

	assign advance  = vld_s1 && buf_free;
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			begin_s1 <= begin_req;
			final_s1 <= final_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= jsu_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= jsu_pkg::PH_IDLE;
			st_q.hex_count     <= 2'd0;
			st_q.code_point    <= 16'h0000;
			st_q.decoded_count <= 17'd0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	jsu_decode u_decode (
		.st         (st_q),
		.max_length (max_len_q),
		.in_byte    (byte_s1),
		.begin_req  (begin_s1),
		.final_req  (final_s1),
		.st_next    (st_next),
		.bundle     (bundle)
	);

	jsu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.bundle    (bundle),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.status    (status),
		.run_end   (run_end)
	);

endmodule

// File: design/jsu_checker.sv
// ---------------------------------------------------------------------------
// jsu_checker
// port level checks for the json string unescaper, bound to the top level
// ---------------------------------------------------------------------------
`include "json_string_unescaper_top_macros.svh"

module jsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic [2:0]  status,
	input logic        run_end
);

	// a stalled result word holds
	`JSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(status) && $stable(run_end), "result word changed while stalled")

	// done and error words always close the run of their source word
	`JSU_ASSERT_NOW(a_status_ends_run, out_valid && status != jsu_pkg::ST_DATA, run_end, "status word not marked as run end")

	// the rest of a run is already buffered, so no gap inside a run
	`JSU_ASSERT_NEXT(a_run_no_gap, out_valid && out_ready && !run_end, out_valid, "gap inside a run of results")

endmodule

bind json_string_unescaper_top jsu_checker u_jsu_checker (.*);

// File: tb/json_string_unescaper_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// json string unescaper checker
// tracks the decoder state from every accepted source word, queues the
// decoded words it must produce and compares each accepted output word
// ---------------------------------------------------------------------------
module json_string_unescaper_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        begin_req,
	input  logic        final_req,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic [2:0]  status,
	input  logic        run_end,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending_words
);

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] stat;
		logic       last;
	} decoded_t;

	decoded_t         decoded_q[$];
	decoded_t         step_q[$];
	decoded_t         got;
	decoded_t         want;
	jsu_pkg::phase_t  scan_phase;
	logic [1:0]       digit_count;
	logic [15:0]      code_acc;
	logic [16:0]      byte_count;
	logic [15:0]      length_limit;
	int               mismatches;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66)
			return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46)
			return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void note_failure(input string what, input decoded_t exp_w,
			input decoded_t act_w);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected byte %02h status %0d end %0b, %s %02h status %0d end %0b",
				$time, what, exp_w.data, exp_w.stat, exp_w.last, "got byte",
				act_w.data, act_w.stat, act_w.last);
	endfunction

	task automatic put_result(input logic [7:0] b, input logic [2:0] st);
		decoded_t w;
		w.data = b;
		w.stat = st;
		w.last = 1'b0;
		step_q = {step_q, w};
	endtask

	task automatic put_data(input logic [7:0] b);
		if (byte_count != jsu_pkg::COUNT_MAX)
			byte_count++;
		put_result(b, jsu_pkg::ST_DATA);
	endtask

	task automatic abort_string(input logic [2:0] st);
		scan_phase = jsu_pkg::PH_IDLE;
		put_result(8'h00, st);
	endtask

	task automatic decode_word(input logic [7:0] c, input logic opening, input logic closing);
		logic [7:0]  b;
		logic        simple;
		int          d;
		logic [15:0] cp;
		step_q.delete();
		b = 8'h00;
		if (opening) begin
			digit_count = 2'd0;
			code_acc    = 16'h0000;
			byte_count  = 17'd0;
			if (c != jsu_pkg::CH_QUOTE)
				abort_string(jsu_pkg::ST_NOQUOTE);
			else
				scan_phase = jsu_pkg::PH_BODY;
		end else if (scan_phase == jsu_pkg::PH_BODY) begin
			// closing quote is taken even when the length limit is reached
			if (c == jsu_pkg::CH_QUOTE) begin
				scan_phase = jsu_pkg::PH_IDLE;
				put_result(8'h00, jsu_pkg::ST_DONE);
			end else if (byte_count >= {1'b0, length_limit}) begin
				abort_string(jsu_pkg::ST_TOOLONG);
			end else if (c == jsu_pkg::CH_BSLASH) begin
				scan_phase = jsu_pkg::PH_ESC;
			end else if (c < jsu_pkg::CTRL_LIM) begin
				abort_string(jsu_pkg::ST_CTRL);
			end else begin
				put_data(c);
			end
		end else if (scan_phase == jsu_pkg::PH_ESC) begin
			simple = 1'b1;
			case (c)
				jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: b = c;
				8'h62: b = 8'h08;	// b
				8'h66: b = 8'h0C;	// f
				8'h6E: b = 8'h0A;	// n
				8'h72: b = 8'h0D;	// r
				8'h74: b = 8'h09;	// t
				default: simple = 1'b0;
			endcase
			if (simple) begin
				scan_phase = jsu_pkg::PH_BODY;
				put_data(b);
			end else if (c == jsu_pkg::CH_U) begin
				scan_phase  = jsu_pkg::PH_HEX;
				digit_count = 2'd0;
				code_acc    = 16'h0000;
			end else begin
				abort_string(jsu_pkg::ST_BADESC);
			end
		end else if (scan_phase == jsu_pkg::PH_HEX) begin
			d = hex_digit(c);
			if (d < 0) begin
				abort_string(jsu_pkg::ST_BADHEX);
			end else begin
				code_acc = {code_acc[11:0], d[3:0]};
				if (digit_count == 2'd3) begin
					cp          = code_acc;
					digit_count = 2'd0;
					scan_phase  = jsu_pkg::PH_BODY;
					// utf-8 in one, two or three bytes, surrogates encoded as is
					if (cp < 16'h0080) begin
						put_data(cp[7:0]);
					end else if (cp < 16'h0800) begin
						put_data({3'b110, cp[10:6]});
						put_data({2'b10, cp[5:0]});
					end else begin
						put_data({4'b1110, cp[15:12]});
						put_data({2'b10, cp[11:6]});
						put_data({2'b10, cp[5:0]});
					end
				end else begin
					digit_count++;
				end
			end
		end
		if (closing && scan_phase != jsu_pkg::PH_IDLE)
			abort_string(jsu_pkg::ST_UNTERM);
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
		decoded_q = {decoded_q, step_q};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_phase    = jsu_pkg::PH_IDLE;
			digit_count   = 2'd0;
			code_acc      = 16'h0000;
			byte_count    = 17'd0;
			length_limit  = jsu_pkg::MAX_LEN_RESET;
			mismatches    = 0;
			decoded_q.delete();
			fail_count    <= 0;
			pending_words <= 0;
		end else begin
			if (cfg_we)
				length_limit = cfg_wdata;
			if (in_valid && in_ready)
				decode_word(in_byte, begin_req, final_req);
			if (out_valid && out_ready) begin
				got.data = out_byte;
				got.stat = status;
				got.last = run_end;
				if (decoded_q.size() == 0) begin
					note_failure("unexpected word", '0, got);
				end else begin
					want = decoded_q.pop_front();
					if (got.data !== want.data || got.stat !== want.stat ||
							got.last !== want.last)
						note_failure("mismatch", want, got);
				end
			end
			fail_count    <= mismatches;
			pending_words <= decoded_q.size();
		end
	end

endmodule

// File: tb/json_string_unescaper_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// json string unescaper regression
// directed strings for the newline escape, two utf-8 widths and each error, then
// random strings under several length limits, with random stalls on both sides in all passes but one
// ---------------------------------------------------------------------------
module json_string_unescaper_top_test;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  in_byte   = 8'h00;
	logic        begin_req = 1'b0;
	logic        final_req = 1'b0;
	logic        out_ready = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;
	logic        quiet     = 1'b0;	// no idling on either side while set
	logic        in_ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic [2:0]  status;
	logic        run_end;
	int          fail_count;
	int          pending_words;
	int          words_sent = 0;

	always #4 clk = ~clk;

	json_string_unescaper_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.begin_req (begin_req),
		.final_req (final_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.status    (status),
		.run_end   (run_end),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	json_string_unescaper_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.begin_req     (begin_req),
		.final_req     (final_req),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.status        (status),
		.run_end       (run_end),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 24);
	end

	task automatic send_word(input logic [7:0] b, input logic opening, input logic closing);
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		begin_req <= opening;
		final_req <= closing;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_text(input string s, input bit opening, input bit closing);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], opening && i == 0, closing && i == s.len() - 1);
	endtask

	// a string body word that may end the source early
	task automatic send_body(input logic [7:0] b, output bit ended);
		ended = ($urandom_range(99) < 2);
		send_word(b, 1'b0, ended);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_words != 0);
		// ignored words give no result but may still be in flight
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return 8'h30 + {4'h0, v};
		return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		case ($urandom_range(3))
			0: return 8'($urandom_range(8'h00, 8'h2F));
			1: return 8'($urandom_range(8'h3A, 8'h40));
			2: return 8'($urandom_range(8'h47, 8'h60));
			default: return 8'($urandom_range(8'h67, 8'hFF));
		endcase
	endfunction

	task automatic send_random_string(input int n_chars);
		int          kind;
		int          n_good;
		bit          ended;
		logic [7:0]  b;
		logic [15:0] cp;
		logic [7:0]  esc_set [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
		send_word(jsu_pkg::CH_QUOTE, 1'b1, $urandom_range(49) == 0);
		for (int i = 0; i < n_chars; i++) begin
			kind = $urandom_range(99);
			if (kind < 45 || kind >= 92) begin
				do
					b = 8'($urandom_range(8'h20, 8'hFF));
				while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
				send_body(b, ended);
				if (ended)
					return;
			end else if (kind < 60) begin
				send_body(jsu_pkg::CH_BSLASH, ended);
				if (ended)
					return;
				send_body(esc_set[$urandom_range(7)], ended);
				if (ended)
					return;
			end else if (kind < 80) begin
				case ($urandom_range(2))
					0: cp = 16'($urandom_range(16'h0000, 16'h007F));
					1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
					default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
				send_body(jsu_pkg::CH_BSLASH, ended);
				if (ended)
					return;
				send_body(jsu_pkg::CH_U, ended);
				if (ended)
					return;
				for (int k = 3; k >= 0; k--) begin
					send_body(hex_char(cp[k*4 +: 4], 1'($urandom_range(1))), ended);
					if (ended)
						return;
				end
			end else if (kind < 90) begin
				// broken string: the rest of it is ignored by the block
				if (kind < 84) begin
					send_body(8'($urandom_range(8'h00, 8'h1F)), ended);
				end else if (kind < 87) begin
					send_word(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
					b = 8'($urandom);
					case (b)
						8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74,
						jsu_pkg::CH_U: b = 8'h61;
						default: ;
					endcase
					send_body(b, ended);
				end else begin
					send_word(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
					send_word(jsu_pkg::CH_U, 1'b0, 1'b0);
					n_good = $urandom_range(3);
					for (int k = 0; k < n_good; k++)
						send_word(hex_char(4'($urandom), 1'($urandom_range(1))), 1'b0, 1'b0);
					send_body(non_hex_char(), ended);
				end
				repeat ($urandom_range(2))
					send_word(8'($urandom), 1'b0, 1'b0);
				return;
			end else begin
				// left open; the next opening quote starts anew
				return;
			end
		end
		send_word(jsu_pkg::CH_QUOTE, 1'b0, $urandom_range(19) == 0);
	endtask

	initial begin
		logic [15:0] limits [6];
		int          stop_at;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle byte, missing quote, an escape and a two-byte utf-8 sequence
		send_word("x", 1'b0, 1'b0);
		send_word("a", 1'b1, 1'b0);
		send_word(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_text("\\n\\u07fF\"", 1'b0, 1'b0);
		// control byte, bad escape, bad hex on the last byte, trailing backslash
		send_word(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
		send_word(8'h1F, 1'b0, 1'b0);
		send_text("\"\\q", 1'b1, 1'b0);
		send_text("\"\\u", 1'b1, 1'b0);
		send_word("g", 1'b0, 1'b1);
		send_text("\"\\", 1'b1, 1'b1);

		// zero limit still accepts the closing quote
		write_limit(16'd0);
		send_text("\"a", 1'b1, 1'b0);
		send_text("\"\"", 1'b1, 1'b0);
		// length is checked at the backslash, so a wide \u runs past the limit
		write_limit(16'd1);
		send_text("\"\\uFFFFa", 1'b1, 1'b0);

		limits[0] = 16'hFFFF;
		limits[1] = 16'd6;
		limits[2] = 16'($urandom_range(1, 12));
		limits[3] = 16'd0;
		limits[4] = jsu_pkg::MAX_LEN_RESET;
		limits[5] = 16'($urandom_range(2, 16));
		for (int p = 0; p < 6; p++) begin
			write_limit(limits[p]);
			quiet   = (p == 2);
			stop_at = words_sent + 24;
			while (words_sent < stop_at) begin
				if ($urandom_range(99) < 12)
					send_word(8'($urandom), $urandom_range(3) == 0, $urandom_range(9) == 0);
				else if ($urandom_range(9) == 0)
					send_random_string($urandom_range(11, 20));
				else
					send_random_string($urandom_range(0, 10));
			end
		end
		quiet = 1'b0;

		wait_drained();
		if (fail_count == 0 && pending_words == 0)
			$display("json_string_unescaper_top regression: pass");
		else
			$display("json_string_unescaper_top regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("json_string_unescaper_top regression: fail");
		$finish;
	end

endmodule
